### hw/rtl/srbf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srbf_pkg: shared types and functions of the sample ring record framer
// Request and result payloads, the command passed from the front to the
// back, and the base64 character encoding.
// ----------------------------------------------------------------------------
package srbf_pkg;

    localparam int unsigned SLOT_W = 7;
    localparam int unsigned CNT_W  = 6;

    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;

    typedef struct packed {
        logic        req_type;
        logic [31:0] chan0_bits;
        logic [31:0] chan1_bits;
        logic [31:0] chan2_bits;
        logic [31:0] chan3_bits;
    } in_t;

    typedef struct packed {
        logic [47:0] index_text;
        logic [31:0] chan0_text;
        logic [31:0] chan1_text;
        logic [31:0] chan2_text;
        logic [31:0] chan3_text;
        logic        backlog_error;
        logic [31:0] backlog_amount;
        logic        last;
    } out_t;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_ERROR,
        CMD_STREAM
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [31:0]       word;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
        logic [3:0][31:0]  data;
    } cmd_t;

    function automatic logic [7:0] b64_char(input logic [5:0] d);
        logic [7:0] c;
        if (d < 6'd26) begin
            c = CHAR_UPPER_A + {2'b00, d};
        end else if (d < 6'd52) begin
            c = CHAR_LOWER_A + {2'b00, 6'(d - 6'd26)};
        end else if (d < 6'd62) begin
            c = CHAR_ZERO + {2'b00, 6'(d - 6'd52)};
        end else if (d == 6'd62) begin
            c = CHAR_PLUS;
        end else begin
            c = CHAR_SLASH;
        end
        return c;
    endfunction

    function automatic logic [47:0] encode_index(input logic [31:0] idx);
        logic [35:0] v;
        logic [47:0] t;
        v = {4'b0000, idx};
        for (int k = 0; k < 6; k++) begin
            t[8*k +: 8] = b64_char(v[6*k +: 6]);
        end
        return t;
    endfunction

    function automatic logic [31:0] encode_word(input logic [31:0] w);
        logic [31:0] t;
        for (int k = 0; k < 4; k++) begin
            t[8*k +: 8] = b64_char(w[8 + 6*k +: 6]);
        end
        return t;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/srbf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srbf_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module srbf_ram #(
    parameter int unsigned WIDTH = 128,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/srbf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srbf_front: request intake and classification
// Tracks the stored and sent indices, decides each flush and issues
// commands to the back end.
// ----------------------------------------------------------------------------
module srbf_front #(
    parameter int unsigned RING_DEPTH = 128
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire srbf_pkg::in_t   s_data,
    output logic                 cmd_valid,
    input  wire logic            cmd_ready,
    output srbf_pkg::cmd_t       cmd
);

    localparam int unsigned AW = $clog2(RING_DEPTH);
    localparam logic [31:0] HALF = 32'(RING_DEPTH / 2);
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

    logic [31:0]   stored_index_reg, stored_index_next;
    logic [31:0]   sent_index_reg, sent_index_next;
    logic [AW-1:0] stored_slot_reg, stored_slot_next;
    logic [AW-1:0] sent_slot_reg, sent_slot_next;
    logic          error_reg, error_next;
    logic [31:0]   backlog;
    logic          accept;

    assign s_ready = cmd_ready;
    assign accept  = s_valid && s_ready;
    assign backlog = stored_index_reg - sent_index_reg;

    always_comb begin
        stored_index_next = stored_index_reg;
        sent_index_next   = sent_index_reg;
        stored_slot_next  = stored_slot_reg;
        sent_slot_next    = sent_slot_reg;
        error_next        = error_reg;
        cmd_valid         = 1'b0;
        cmd.kind          = srbf_pkg::CMD_PUSH;
        cmd.word          = backlog;
        cmd.slot          = srbf_pkg::SLOT_W'(stored_slot_reg);
        cmd.count         = backlog[srbf_pkg::CNT_W-1:0];
        cmd.data          = {s_data.chan3_bits, s_data.chan2_bits,
                             s_data.chan1_bits, s_data.chan0_bits};
        if (accept) begin
            if (s_data.req_type == srbf_pkg::REQ_PUSH) begin
                cmd_valid         = 1'b1;
                stored_index_next = stored_index_reg + 32'd1;
                stored_slot_next  = (stored_slot_reg == LAST_SLOT) ? '0
                                                                   : stored_slot_reg + 1'b1;
            end else if (!error_reg) begin
                if (backlog >= HALF) begin
                    cmd_valid  = 1'b1;
                    cmd.kind   = srbf_pkg::CMD_ERROR;
                    error_next = 1'b1;
                end else if (backlog != 32'd0) begin
                    cmd_valid       = 1'b1;
                    cmd.kind        = srbf_pkg::CMD_STREAM;
                    cmd.word        = sent_index_reg;
                    cmd.slot        = srbf_pkg::SLOT_W'(sent_slot_reg);
                    sent_index_next = stored_index_reg;
                    sent_slot_next  = stored_slot_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_index_reg <= '0;
            sent_index_reg   <= '0;
            stored_slot_reg  <= '0;
            sent_slot_reg    <= '0;
            error_reg        <= 1'b0;
        end else begin
            stored_index_reg <= stored_index_next;
            sent_index_reg   <= sent_index_next;
            stored_slot_reg  <= stored_slot_next;
            sent_slot_reg    <= sent_slot_next;
            error_reg        <= error_next;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/srbf_cmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srbf_cmd_fifo: two-entry command queue
// Decouples the front end from the back end so that each may stall alone.
// ----------------------------------------------------------------------------
module srbf_cmd_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire srbf_pkg::cmd_t in_cmd,
    output logic                out_valid,
    input  wire logic           out_ready,
    output srbf_pkg::cmd_t      out_cmd
);

    srbf_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     fill_reg;
    logic           push;
    logic           pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

### hw/rtl/srbf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srbf_back: command execution and record streaming
// Writes pushed samples into the ring, reports overflows and streams
// encoded records through the result register.
// ----------------------------------------------------------------------------
module srbf_back #(
    parameter int unsigned RING_DEPTH = 128
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire srbf_pkg::cmd_t cmd,
    output logic                m_valid,
    input  wire logic           m_ready,
    output srbf_pkg::out_t      m_data
);

    localparam int unsigned AW = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t                        state_reg;
    logic                          m_valid_reg;
    srbf_pkg::out_t                m_data_reg;
    logic [31:0]                   index_reg;
    logic [AW-1:0]                 slot_reg;
    logic [srbf_pkg::CNT_W-1:0]    left_reg;
    logic [AW-1:0]                 slot_step;
    logic                          out_free;
    logic                          out_load;
    logic                          final_rec;
    logic                          ram_we;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [3:0][31:0]              ram_rdata;

    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = out_free && (((state_reg == ST_IDLE) && cmd_valid &&
                                     (cmd.kind == srbf_pkg::CMD_ERROR)) ||
                                    (state_reg == ST_EMIT));
    assign slot_step = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
    assign final_rec = (left_reg == srbf_pkg::CNT_W'(1));

    always_comb begin
        cmd_ready = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = slot_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    unique case (cmd.kind)
                        srbf_pkg::CMD_PUSH: begin
                            cmd_ready = 1'b1;
                            ram_we    = 1'b1;
                        end
                        srbf_pkg::CMD_ERROR: begin
                            cmd_ready = out_free;
                        end
                        default: begin
                            cmd_ready = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                ram_re = 1'b1;
            end
            default: begin
                if (out_free && !final_rec) begin
                    ram_re    = 1'b1;
                    ram_raddr = slot_step;
                end
            end
        endcase
    end

    srbf_ram #(
        .WIDTH (128),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cmd.slot[AW-1:0]),
        .wdata (cmd.data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid && cmd.kind == srbf_pkg::CMD_ERROR && out_free) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.index_text      <= '0;
                        m_data_reg.chan0_text      <= '0;
                        m_data_reg.chan1_text      <= '0;
                        m_data_reg.chan2_text      <= '0;
                        m_data_reg.chan3_text      <= '0;
                        m_data_reg.backlog_error   <= 1'b1;
                        m_data_reg.backlog_amount  <= cmd.word;
                        m_data_reg.last            <= 1'b1;
                    end else if (cmd_valid && cmd.kind == srbf_pkg::CMD_STREAM) begin
                        index_reg <= cmd.word;
                        slot_reg  <= cmd.slot[AW-1:0];
                        left_reg  <= cmd.count;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_EMIT;
                end
                default: begin
                    if (out_free) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.index_text      <= srbf_pkg::encode_index(index_reg);
                        m_data_reg.chan0_text      <= srbf_pkg::encode_word(ram_rdata[0]);
                        m_data_reg.chan1_text      <= srbf_pkg::encode_word(ram_rdata[1]);
                        m_data_reg.chan2_text      <= srbf_pkg::encode_word(ram_rdata[2]);
                        m_data_reg.chan3_text      <= srbf_pkg::encode_word(ram_rdata[3]);
                        m_data_reg.backlog_error   <= 1'b0;
                        m_data_reg.backlog_amount  <= '0;
                        m_data_reg.last            <= final_rec;
                        if (final_rec) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            index_reg <= index_reg + 32'd1;
                            slot_reg  <= slot_step;
                            left_reg  <= left_reg - srbf_pkg::CNT_W'(1);
                        end
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### hw/rtl/sample_ring_base64_record_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sample_ring_base64_record_framer: sample ring with base64 record output
// A request is accepted each cycle while the two-entry command queue has room.
// A push is written to the ring as it leaves the queue.
// A flush's first record passes the queue and the READ and EMIT states; the rest
// follow one per cycle unless the output stalls, paced by the single ring read port.
// Reset clears indices, the error latch and the queue; ring contents are kept.
// ----------------------------------------------------------------------------
module sample_ring_base64_record_framer #(
    parameter int unsigned RING_DEPTH = 128
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire srbf_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output srbf_pkg::out_t      m_data
);

    logic           fc_valid;
    logic           fc_ready;
    srbf_pkg::cmd_t fc_cmd;
    logic           bc_valid;
    logic           bc_ready;
    srbf_pkg::cmd_t bc_cmd;

    srbf_front #(
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (fc_valid),
        .cmd_ready (fc_ready),
        .cmd       (fc_cmd)
    );

    srbf_cmd_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fc_valid),
        .in_ready  (fc_ready),
        .in_cmd    (fc_cmd),
        .out_valid (bc_valid),
        .out_ready (bc_ready),
        .out_cmd   (bc_cmd)
    );

    srbf_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (bc_valid),
        .cmd_ready (bc_ready),
        .cmd       (bc_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire
